// ----- src/pcm_pkg.sv -----
// Shared types, constants and helpers for the pixel color matrix block.
// No dependencies; every module of the block imports this package.
package pcm_pkg;

  // Coefficient format: signed, CoefFracBits fraction bits
  localparam int CoefFracBits = 8;
  localparam int CoefWidth    = 16;
  localparam int Channels     = 4;

  // Unpremultiplied channel value, Q.16 with 1.0 = 65536
  localparam int UnitWidth    = 17;
  typedef logic [UnitWidth-1:0] unit_t;
  localparam unit_t UnitOne   = unit_t'(65536);

  // One matrix row or the bias word: four signed slots (r, g, b, a)
  typedef logic [Channels-1:0][CoefWidth-1:0] row_t;

  // Datapath widths
  localparam int ProdWidth    = CoefWidth + UnitWidth + 1;
  localparam int AccWidth     = ProdWidth + 3;
  localparam logic signed [AccWidth-1:0] RoundHalf =
    AccWidth'(64'd1 << (CoefFracBits - 1));
  localparam logic signed [AccWidth-1:0] AccTop =
    AccWidth'(64'd1 << (CoefFracBits + 16));

  // Pipeline depth
  localparam int DivStages    = 16;
  localparam int MacStages    = 3;
  localparam int LineDepth    = DivStages + MacStages + 1;
  localparam int Latency      = LineDepth + 1;

  // Configuration register indexes
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 64;
  typedef enum logic [CfgIdxWidth-1:0] {
    RegRedRow   = 3'd0,
    RegGreenRow = 3'd1,
    RegBlueRow  = 3'd2,
    RegAlphaRow = 3'd3,
    RegBias     = 3'd4,
    RegAlphaOnly = 3'd5
  } cfg_reg_e;

  // Row with 1.0 on diagonal slot diag and zero elsewhere
  function automatic row_t ident_row(input int diag);
    row_t r;
    r = '0;
    r[diag] = CoefWidth'(64'd1 << CoefFracBits);
    return r;
  endfunction

endpackage

// ----- src/pcm_div.sv -----
// Pipelined restoring divider: u = floor((num*65536 + den/2) / den), saturated at 1.0.
// One quotient bit per stage; depends on pcm_pkg.
module pcm_div (
  input  logic          clk_i,
  input  logic [7:0]    num_i,
  input  logic [7:0]    den_i,
  output pcm_pkg::unit_t quo_o
);
  import pcm_pkg::*;

  logic [7:0]  rem_q  [DivStages];
  logic [15:0] low_q  [DivStages];
  logic [15:0] quo_q  [DivStages];
  logic [7:0]  den_q  [DivStages];
  logic        zero_q [DivStages];
  logic        sat_q  [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic [7:0]  rem_s;
    logic [15:0] low_s;
    logic [15:0] quo_s;
    logic [7:0]  den_s;
    logic        zero_s;
    logic        sat_s;
    logic [8:0]  trial;

    if (k == 0) begin : g_first
      // start with the color as the partial remainder, half the divisor below it
      assign zero_s = (den_i == 8'd0);
      assign sat_s  = (num_i >= den_i);
      assign rem_s  = sat_s ? 8'd0 : num_i;
      assign low_s  = 16'(den_i[7:1]);
      assign quo_s  = '0;
      assign den_s  = den_i;
    end else begin : g_next
      assign zero_s = zero_q[k-1];
      assign sat_s  = sat_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign low_s  = low_q[k-1];
      assign quo_s  = quo_q[k-1];
      assign den_s  = den_q[k-1];
    end

    assign trial = {rem_s, low_s[15]};

    // shift in one dividend bit, subtract when it fits
    always_ff @(posedge clk_i) begin
      den_q[k]  <= den_s;
      zero_q[k] <= zero_s;
      sat_q[k]  <= sat_s;
      low_q[k]  <= {low_s[14:0], 1'b0};
      if (trial >= {1'b0, den_s}) begin
        rem_q[k] <= 8'(trial - {1'b0, den_s});
        quo_q[k] <= {quo_s[14:0], 1'b1};
      end else begin
        rem_q[k] <= trial[7:0];
        quo_q[k] <= {quo_s[14:0], 1'b0};
      end
    end
  end

  // zero alpha gives zero, color at or above alpha saturates
  always_comb begin
    if (zero_q[DivStages-1]) begin
      quo_o = '0;
    end else if (sat_q[DivStages-1]) begin
      quo_o = UnitOne;
    end else begin
      quo_o = unit_t'(quo_q[DivStages-1]);
    end
  end

endmodule

// ----- src/pcm_mac.sv -----
// Matrix multiply-accumulate: product, sum and round/clamp stages.
// Three register stages; depends on pcm_pkg.
module pcm_mac (
  input  logic                            clk_i,
  input  logic                            fast_i,
  input  pcm_pkg::row_t  [3:0]            rows_i,
  input  pcm_pkg::row_t                   bias_i,
  input  pcm_pkg::unit_t [3:0]            opnd_i,
  input  logic [7:0]                      alpha_i,
  output pcm_pkg::unit_t [3:0]            val_o
);
  import pcm_pkg::*;

  logic signed [ProdWidth-1:0] prod_d [Channels][Channels];
  logic signed [ProdWidth-1:0] prod_q [Channels][Channels];
  logic signed [AccWidth-1:0]  acc_d  [Channels];
  logic signed [AccWidth-1:0]  acc_q  [Channels];
  unit_t                       val_d  [Channels];
  unit_t                       val_q  [Channels];
  logic [7:0]                  alpha_m_q;
  logic [7:0]                  alpha_s_q;

  // multiply every coefficient by its operand
  always_comb begin
    for (int k = 0; k < Channels; k++) begin
      for (int j = 0; j < Channels; j++) begin
        prod_d[k][j] = $signed(rows_i[k][j]) * $signed({1'b0, opnd_i[j]});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    alpha_m_q <= alpha_i;
  end

  // add the row products plus bias or rounding half
  always_comb begin
    logic signed [AccWidth-1:0] base;
    for (int k = 0; k < Channels; k++) begin
      if (fast_i) begin
        base = RoundHalf;
      end else begin
        base = $signed({{(AccWidth-CoefWidth-16){bias_i[k][CoefWidth-1]}},
                        bias_i[k], 16'b0});
      end
      acc_d[k] = base + AccWidth'(prod_q[k][0]) + AccWidth'(prod_q[k][1])
               + AccWidth'(prod_q[k][2]) + AccWidth'(prod_q[k][3]);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    alpha_s_q <= alpha_m_q;
  end

  // round and clamp: 0..alpha on the fast path, 0..1.0 otherwise
  always_comb begin
    logic signed [AccWidth-1:0] sh;
    for (int k = 0; k < Channels; k++) begin
      sh = '0;
      if (acc_q[k][AccWidth-1]) begin
        val_d[k] = '0;
      end else if (fast_i) begin
        sh = acc_q[k] >>> CoefFracBits;
        if (sh > $signed(AccWidth'(alpha_s_q))) begin
          val_d[k] = unit_t'(alpha_s_q);
        end else begin
          val_d[k] = unit_t'(sh);
        end
      end else if (acc_q[k] > AccTop) begin
        val_d[k] = UnitOne;
      end else begin
        sh = (acc_q[k] + RoundHalf) >>> CoefFracBits;
        val_d[k] = unit_t'(sh);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_comb begin
    for (int k = 0; k < Channels; k++) begin
      val_o[k] = val_q[k];
    end
  end

endmodule

// ----- src/pixel_color_matrix_core.sv -----
// Top level of the pixel color matrix block: config registers, pipeline control, output.
// Depends on pcm_pkg, pcm_div and pcm_mac.
//
// Usage:
//   Pixels enter on pixel_in_i with start_i; busy_o is always low, so a pixel
//   is taken in every cycle that start_i is high. Each result appears on
//   pixel_out_o for one cycle with done_o high, in input order. Throughput is
//   one pixel per clock. A pixel passes through the 16-stage unpremultiply
//   divider (one quotient bit per stage), then one stage each for the
//   coefficient products, the row sums, rounding/clamping and the
//   premultiply product, and the output register.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_addr_i
//   (0..3 red, green, blue, alpha rows; 4 biases; 5 alpha-only mode);
//   indexes beyond 5 are ignored. Write only when no pixel is in flight.
//   Reset loads the identity matrix, zero bias, ARGB mode, and drops any
//   pixel in flight. The receiver cannot stall; done_o is a strobe.
module pixel_color_matrix_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [31:0]                          pixel_in_i,
  output logic                                 done_o,
  output logic [31:0]                          pixel_out_o,
  input  logic                                 cfg_we_i,
  input  logic [pcm_pkg::CfgIdxWidth-1:0]      cfg_addr_i,
  input  logic [pcm_pkg::CfgDataWidth-1:0]     cfg_wdata_i
);
  import pcm_pkg::*;

  row_t        rows_q [Channels];
  row_t        bias_q;
  logic        aonly_q;
  logic        ident;
  logic        fast;
  logic        accept;

  logic        vld_q [LineDepth];
  logic [31:0] px_q  [LineDepth];

  logic [7:0]  in_alpha;
  logic [7:0]  in_ch [3];
  unit_t       u_div [3];
  logic [31:0] px_t;
  logic [7:0]  alpha_t;
  unit_t       ua_t;
  unit_t [3:0] opnd;
  row_t  [3:0] rows_p;
  unit_t [3:0] val;

  logic [33:0] mul_q [3];
  logic [7:0]  fv_q [3];
  logic [7:0]  oa_q;
  logic [31:0] out_d;
  logic [31:0] out_q;
  logic        done_q;

  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Channels; k++) begin
        rows_q[k] <= ident_row(k);
      end
      bias_q  <= '0;
      aonly_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegRedRow:    rows_q[0] <= cfg_wdata_i;
        RegGreenRow:  rows_q[1] <= cfg_wdata_i;
        RegBlueRow:   rows_q[2] <= cfg_wdata_i;
        RegAlphaRow:  rows_q[3] <= cfg_wdata_i;
        RegBias:      bias_q    <= cfg_wdata_i;
        RegAlphaOnly: aonly_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // decode the path from the matrix and the alpha-only mode
  always_comb begin
    ident = (bias_q == '0);
    for (int k = 0; k < Channels; k++) begin
      ident = ident & (rows_q[k] == ident_row(k));
    end
    fast = ~aonly_q & (bias_q == '0) & (rows_q[3] == ident_row(3))
         & (rows_q[0][3] == '0) & (rows_q[1][3] == '0) & (rows_q[2][3] == '0);
  end

  // split the incoming pixel for the dividers
  always_comb begin
    if (aonly_q) begin
      in_alpha = pixel_in_i[7:0];
      in_ch[0] = '0;
      in_ch[1] = '0;
      in_ch[2] = '0;
    end else begin
      in_alpha = pixel_in_i[31:24];
      in_ch[0] = pixel_in_i[23:16];
      in_ch[1] = pixel_in_i[15:8];
      in_ch[2] = pixel_in_i[7:0];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    pcm_div u_div_ch (
      .clk_i (clk_i),
      .num_i (in_ch[c]),
      .den_i (in_alpha),
      .quo_o (u_div[c])
    );
  end

  // carry valid bits and pixels alongside the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LineDepth; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < LineDepth; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    px_q[0] <= pixel_in_i;
    for (int i = 1; i < LineDepth; i++) begin
      px_q[i] <= px_q[i-1];
    end
  end

  // pick matrix operands: raw channels on the fast path, unpremultiplied otherwise
  assign px_t    = px_q[DivStages-1];
  assign alpha_t = aonly_q ? px_t[7:0] : px_t[31:24];
  assign ua_t    = unit_t'({alpha_t, alpha_t}) + unit_t'(alpha_t[7]);

  always_comb begin
    if (fast) begin
      opnd[0] = unit_t'(px_t[23:16]);
      opnd[1] = unit_t'(px_t[15:8]);
      opnd[2] = unit_t'(px_t[7:0]);
    end else begin
      opnd[0] = u_div[0];
      opnd[1] = u_div[1];
      opnd[2] = u_div[2];
    end
    opnd[3] = ua_t;
    for (int k = 0; k < Channels; k++) begin
      rows_p[k] = rows_q[k];
    end
  end

  pcm_mac u_mac (
    .clk_i   (clk_i),
    .fast_i  (fast),
    .rows_i  (rows_p),
    .bias_i  (bias_q),
    .opnd_i  (opnd),
    .alpha_i (alpha_t),
    .val_o   (val)
  );

  // premultiply products, output alpha, and hold the fast path channels
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      mul_q[k] <= 34'(val[k]) * 34'(val[3]);
      fv_q[k]  <= val[k][7:0];
    end
    oa_q <= 8'((({8'b0, val[3], 8'b0} - 33'(val[3])) + 33'd32768) >> 16);
  end

  // scale by 255, round and assemble the result
  always_comb begin
    logic [41:0] sc [3];
    logic [7:0]  oc [3];
    logic [31:0] px_o;
    logic [7:0]  a_o;
    px_o = px_q[LineDepth-1];
    a_o  = px_o[31:24];
    for (int k = 0; k < 3; k++) begin
      sc[k] = ({mul_q[k], 8'b0} - 42'(mul_q[k])) + 42'h0_8000_0000;
      oc[k] = sc[k][39:32];
    end
    if (ident) begin
      out_d = aonly_q ? {24'b0, px_o[7:0]} : px_o;
    end else if (fast) begin
      out_d = {a_o, fv_q[0], fv_q[1], fv_q[2]};
    end else if (aonly_q) begin
      out_d = {24'b0, oa_q};
    end else begin
      out_d = {oa_q, oc[0], oc[1], oc[2]};
    end
  end

  // register the result and its strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[LineDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign done_o      = done_q;
  assign pixel_out_o = out_q;

  // every transfer in produces exactly one strobe
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted pixel did not produce a result on time");

  a_out_from_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result strobe without a matching accepted pixel");

endmodule

// ----- sim/pixel_color_matrix_core_tb.sv -----
// Self-checking testbench for pixel_color_matrix_core: drives pixels and matrix
// settings, predicts each output pixel and compares it. Depends on pcm_pkg.
module pixel_color_matrix_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcm_pkg::*;

  localparam int Frac = CoefFracBits;
  localparam int WatchLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [31:0] pixel_in_i = '0;
  logic        done_o;
  logic [31:0] pixel_out_o;
  logic        cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_addr_i = '0;
  logic [CfgDataWidth-1:0] cfg_wdata_i = '0;

  pixel_color_matrix_core u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Local copy of the matrix registers
  logic [63:0] mat_row [4];
  logic [63:0] bias_word;
  logic        alpha_only;

  logic [31:0] pixel_q [$];
  int  err_cnt = 0;
  int  idle_pct = 0;
  int  quiet_cycles = 0;

  function automatic longint coef(input logic [63:0] w, input int k);
    return longint'($signed(w[16*k +: 16]));
  endfunction

  function automatic longint fdiv_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic bit is_ident(input logic [63:0] w, input int d);
    return w == (64'(1 << Frac) << (16 * d));
  endfunction

  function automatic longint clip(input longint v, input longint hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Compute the transformed pixel for the current matrix
  function automatic logic [31:0] matrix_pixel(input logic [31:0] px);
    longint a, acc, top, q;
    longint ch[3], u[4], v[4], res[3], oa, oc[3];
    top = longint'(1) << (Frac + 16);
    if (is_ident(mat_row[0], 0) && is_ident(mat_row[1], 1) && is_ident(mat_row[2], 2) &&
        is_ident(mat_row[3], 3) && bias_word == 0)
      return alpha_only ? {24'h0, px[7:0]} : px;
    if (alpha_only) begin
      a = px[7:0];
      ch[0] = 0; ch[1] = 0; ch[2] = 0;
    end else begin
      a = px[31:24]; ch[0] = px[23:16]; ch[1] = px[15:8]; ch[2] = px[7:0];
    end
    // Fast path: premultiplied 3x3 product, clamp to alpha
    if (!alpha_only && is_ident(mat_row[3], 3) && bias_word == 0 &&
        coef(mat_row[0], 3) == 0 && coef(mat_row[1], 3) == 0 && coef(mat_row[2], 3) == 0) begin
      for (int k = 0; k < 3; k++) begin
        acc = longint'(1) << (Frac - 1);
        for (int j = 0; j < 3; j++) acc += coef(mat_row[k], j) * ch[j];
        res[k] = clip(fdiv_shr(acc, Frac), a);
      end
      return {a[7:0], res[0][7:0], res[1][7:0], res[2][7:0]};
    end
    // General path: unpremultiply, full matrix with bias, premultiply
    for (int j = 0; j < 3; j++) begin
      if (a == 0) u[j] = 0;
      else begin
        q = (ch[j] * 65536 + (a >> 1)) / a;
        u[j] = q > 65536 ? 65536 : q;
      end
    end
    u[3] = (a * 65536 + 127) / 255;
    for (int k = 0; k < 4; k++) begin
      acc = coef(bias_word, k) * 65536;
      for (int j = 0; j < 4; j++) acc += coef(mat_row[k], j) * u[j];
      acc = clip(acc, top);
      v[k] = fdiv_shr(acc + (longint'(1) << (Frac - 1)), Frac);
    end
    oa = (v[3] * 255 + 32768) >>> 16;
    if (alpha_only) return {24'h0, oa[7:0]};
    for (int k = 0; k < 3; k++)
      oc[k] = longint'((64'(v[k] * v[3]) * 64'd255 + 64'h8000_0000) >> 32);
    return {oa[7:0], oc[0][7:0], oc[1][7:0], oc[2][7:0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Check every output transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pixel_q.size() == 0) report_mismatch("unexpected pixel", pixel_out_o, '0);
      else begin
        logic [31:0] want;
        want = pixel_q.pop_front();
        if (pixel_out_o !== want) report_mismatch("pixel_out", pixel_out_o, want);
      end
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("pixel_color_matrix_core_tb: FAIL");
      $finish;
    end
  end

  // Send one pixel, with random idle cycles ahead of it
  task automatic send_pixel(input logic [31:0] px);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    pixel_in_i <= px;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pixel_q.push_back(matrix_pixel(px));
  endtask

  // Hold the input until every pending pixel is out, then let the pipe drain
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegRedRow:   mat_row[0] = val;
      RegGreenRow: mat_row[1] = val;
      RegBlueRow:  mat_row[2] = val;
      RegAlphaRow: mat_row[3] = val;
      RegBias:     bias_word = val;
      default:     alpha_only = val[0];
    endcase
  endtask

  task automatic load_identity();
    write_reg(RegRedRow, 64'(ident_row(0)));
    write_reg(RegGreenRow, 64'(ident_row(1)));
    write_reg(RegBlueRow, 64'(ident_row(2)));
    write_reg(RegAlphaRow, 64'(ident_row(3)));
    write_reg(RegBias, 64'h0);
  endtask

  function automatic logic [31:0] rand_pixel();
    logic [7:0] a;
    a = 8'($urandom);
    // Mostly valid premultiplied pixels, some with color above alpha
    if ($urandom_range(3) == 0) return $urandom;
    return {a, 8'($urandom_range(a)), 8'($urandom_range(a)), 8'($urandom_range(a))};
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(4))
      0: return 16'h0100;
      1: return 16'h0;
      2: return 16'h7fff;
      3: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] rand_row();
    return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  // Identity, fast and general paths and alpha-only mode with extreme pixels
  task automatic test_directed();
    logic [31:0] edge_px [8];
    edge_px = '{32'h0, 32'hffff_ffff, 32'hff00_0000, 32'h00ff_ffff,
                32'h8080_8080, 32'h40ff_0010, 32'h0102_0304, 32'hfe7f_3f1f};
    foreach (edge_px[i]) send_pixel(edge_px[i]);
    drain();
    // Fast path: channel swap with gain, color above alpha clamps
    write_reg(RegRedRow, 64'h0000_0000_0200_0000);
    write_reg(RegGreenRow, 64'h0000_ff00_0000_0100);
    write_reg(RegBlueRow, 64'h0000_0080_0080_0080);
    foreach (edge_px[i]) send_pixel(edge_px[i]);
    drain();
    // General path: alpha gain and biases, zero alpha
    write_reg(RegAlphaRow, 64'h0080_0000_0000_0000);
    write_reg(RegBias, 64'h0040_ff80_0100_8000);
    foreach (edge_px[i]) send_pixel(edge_px[i]);
    drain();
    // Alpha-only mode: general then identity
    write_reg(RegAlphaOnly, 64'h1);
    send_pixel(32'hffff_ff00);
    send_pixel(32'h0000_00ff);
    drain();
    load_identity();
    send_pixel(32'hffff_ff7f);
    send_pixel(32'h0000_0000);
    drain();
    write_reg(RegAlphaOnly, 64'h0);
  endtask

  // Random matrices, modes and pixels at the current idle percentage
  task automatic test_random(input int phases, input int per_phase);
    logic [63:0] row;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(3))
        0: load_identity();
        1: begin
          load_identity();
          row = rand_row();
          write_reg(RegRedRow, {16'h0, row[47:0]});
          row = rand_row();
          write_reg(RegGreenRow, {16'h0, row[47:0]});
          row = rand_row();
          write_reg(RegBlueRow, {16'h0, row[47:0]});
        end
        default: begin
          write_reg(RegRedRow, rand_row());
          write_reg(RegGreenRow, rand_row());
          write_reg(RegBlueRow, rand_row());
          write_reg(RegAlphaRow, rand_row());
          write_reg(RegBias, $urandom_range(1) ? 64'h0 : rand_row());
        end
      endcase
      write_reg(RegAlphaOnly, 64'($urandom_range(4) == 0));
      for (int i = 0; i < per_phase; i++) send_pixel(rand_pixel());
      drain();
    end
  endtask

  initial begin
    mat_row[0] = 64'(ident_row(0));
    mat_row[1] = 64'(ident_row(1));
    mat_row[2] = 64'(ident_row(2));
    mat_row[3] = 64'(ident_row(3));
    bias_word = '0;
    alpha_only = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 29;
    test_directed();
    test_random(10, 43);
    idle_pct = 54;
    test_random(10, 43);
    idle_pct = 0;
    test_random(10, 43);
    drain();
    if (err_cnt == 0) $display("pixel_color_matrix_core_tb: PASS");
    else $display("pixel_color_matrix_core_tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pcm_pkg.sv
src/pcm_div.sv
src/pcm_mac.sv
src/pixel_color_matrix_core.sv
sim/pixel_color_matrix_core_tb.sv
